// ----- rtl/c2s_pkg.sv -----
// shared constants, face codes and sideband structs for the cube to sphere pipeline
// no dependencies, compiled first
package c2s_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int FACE_W    = 3;
  localparam int COORD_W   = 15;
  localparam int OUT_W     = 16;
  localparam int LANES     = 3;
  // magnitude of a cube coordinate or a square, up to one
  localparam int MAG_W     = FRAC_BITS + 1;
  localparam int RAD_W     = 32;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int NUM_W     = ROOT_W + FRAC_BITS + 1;
  // floor(p / 3) = (p * RECIP3) >> RECIP3_SH for p below 2^32
  localparam int RECIP3_SH = 33;
  localparam logic [RECIP3_SH-1:0] RECIP3 = 33'h0_AAAA_AAAB;

  typedef enum logic [FACE_W-1:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_e;

  // cube point as magnitudes and signs, lane 0 is x
  typedef struct packed {
    logic                           bad;
    logic [LANES-1:0]               neg;
    logic [LANES-1:0][MAG_W-1:0]    mag;
  } warp_side_t;

  // warped point as magnitudes and signs
  typedef struct packed {
    logic                           bad;
    logic [LANES-1:0]               neg;
    logic [LANES-1:0][ROOT_W-1:0]   mag;
  } len_side_t;

  typedef struct packed {
    logic                           zero;
    logic [LANES-1:0]               neg;
  } out_side_t;

endpackage

// ----- rtl/c2s_front.sv -----
// front pipeline: clamp, face placement, squares and warp radicand, five stages
// depends on c2s_pkg
module c2s_front (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            in_valid_i,
  output logic                                            in_ready_o,
  input  logic [c2s_pkg::FACE_W-1:0]                      face_i,
  input  logic [c2s_pkg::COORD_W-1:0]                     u_i,
  input  logic [c2s_pkg::COORD_W-1:0]                     v_i,
  output logic                                            out_valid_o,
  input  logic                                            out_ready_i,
  output logic [c2s_pkg::LANES-1:0][c2s_pkg::RAD_W-1:0]   rad_o,
  output c2s_pkg::warp_side_t                             side_o
);
  import c2s_pkg::*;

  localparam int STAGES = 5;
  localparam int AW     = COORD_W + 2;
  localparam int PW     = 2 * MAG_W + 1;
  localparam int MW     = 2 * MAG_W;
  localparam int XW     = MW + RECIP3_SH;
  localparam int HALF   = 1 << (FRAC_BITS - 1);

  logic [STAGES-1:0] v_q;
  logic [STAGES:0]   rdy;

  warp_side_t side_d;
  warp_side_t side_q [STAGES];

  logic [COORD_W-1:0] uc, vc;
  logic [AW-1:0]      a_w, b_w;
  logic               a_neg, b_neg;
  logic [MAG_W-1:0]   a_mag, b_mag;

  logic [LANES-1:0][MAG_W-1:0] sq_d, sq_q;
  logic [LANES-1:0][MW-1:0]    prod_d, prod_q;
  logic [LANES-1:0][MAG_W:0]   sum_d, sum_q, sum3_q;
  logic [LANES-1:0][MW-1:0]    div_d, div_q;
  logic [LANES-1:0][RAD_W-1:0] rad_d, rad_q;

  // stage 0: clamp, map to -1..1 and place on the face
  always_comb begin
    uc    = (u_i > COORD_W'(ONE)) ? COORD_W'(ONE) : u_i;
    vc    = (v_i > COORD_W'(ONE)) ? COORD_W'(ONE) : v_i;
    a_w   = {1'b0, uc, 1'b0} - AW'(ONE);
    b_w   = {1'b0, vc, 1'b0} - AW'(ONE);
    a_neg = a_w[AW-1];
    b_neg = b_w[AW-1];
    a_mag = MAG_W'(a_neg ? (AW'(0) - a_w) : a_w);
    b_mag = MAG_W'(b_neg ? (AW'(0) - b_w) : b_w);
    side_d = '0;
    unique case (face_e'(face_i))
      FACE_PX: begin
        side_d.mag = {a_mag, b_mag, MAG_W'(ONE)};
        side_d.neg = {~a_neg, ~b_neg, 1'b0};
      end
      FACE_NX: begin
        side_d.mag = {a_mag, b_mag, MAG_W'(ONE)};
        side_d.neg = {a_neg, ~b_neg, 1'b1};
      end
      FACE_PY: begin
        side_d.mag = {b_mag, MAG_W'(ONE), a_mag};
        side_d.neg = {b_neg, 1'b0, a_neg};
      end
      FACE_NY: begin
        side_d.mag = {b_mag, MAG_W'(ONE), a_mag};
        side_d.neg = {~b_neg, 1'b1, a_neg};
      end
      FACE_PZ: begin
        side_d.mag = {MAG_W'(ONE), b_mag, a_mag};
        side_d.neg = {1'b0, ~b_neg, a_neg};
      end
      FACE_NZ: begin
        side_d.mag = {MAG_W'(ONE), b_mag, a_mag};
        side_d.neg = {1'b1, ~b_neg, ~a_neg};
      end
      default: side_d.bad = 1'b1;
    endcase
  end

  // stages 1 to 3, lane by lane
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sq_d[l]   = MAG_W'((PW'(side_q[0].mag[l]) * PW'(side_q[0].mag[l]) + PW'(HALF))
                         >> FRAC_BITS);
      prod_d[l] = MW'(sq_q[(l + 1) % LANES]) * MW'(sq_q[(l + 2) % LANES]);
      sum_d[l]  = (MAG_W + 1)'(sq_q[(l + 1) % LANES]) + (MAG_W + 1)'(sq_q[(l + 2) % LANES]);
      div_d[l]  = MW'((XW'(prod_q[l]) * XW'(RECIP3)) >> RECIP3_SH);
    end
  end

  always_comb begin
    logic [RAD_W:0] pos, sub;
    for (int l = 0; l < LANES; l++) begin
      pos      = ((RAD_W + 1)'(1) << (2 * FRAC_BITS)) + (RAD_W + 1)'(div_q[l]);
      sub      = (RAD_W + 1)'(sum3_q[l]) << (FRAC_BITS - 1);
      rad_d[l] = (pos > sub) ? RAD_W'(pos - sub) : '0;
    end
  end

  always_comb begin
    rdy[STAGES] = out_ready_i;
    for (int k = STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) side_q[0] <= side_d;
    for (int k = 1; k < STAGES; k++) begin
      if (rdy[k]) side_q[k] <= side_q[k-1];
    end
    if (rdy[1]) sq_q <= sq_d;
    if (rdy[2]) begin
      prod_q <= prod_d;
      sum_q  <= sum_d;
    end
    if (rdy[3]) begin
      div_q  <= div_d;
      sum3_q <= sum_q;
    end
    if (rdy[4]) rad_q <= rad_d;
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[STAGES-1];
  assign rad_o       = rad_q;
  assign side_o      = side_q[STAGES-1];

endmodule

// ----- rtl/c2s_sqrt.sv -----
// pipelined integer square root, one root bit per stage, several lanes in lockstep
// depends on c2s_pkg
module c2s_sqrt #(
  parameter int NL = c2s_pkg::LANES,
  parameter int W  = c2s_pkg::RAD_W,
  parameter int SW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [NL-1:0][W-1:0]       rad_i,
  input  logic [SW-1:0]              side_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [NL-1:0][W/2-1:0]     root_o,
  output logic [SW-1:0]              side_o
);
  import c2s_pkg::*;

  localparam int N  = W / 2;
  localparam int RW = N + 2;

  logic [N-1:0] v_q;
  logic [N:0]   rdy;

  logic [NL-1:0][RW-1:0] rem_p [N], rem_d [N], rem_q [N];
  logic [NL-1:0][N-1:0]  root_p [N], root_d [N], root_q [N];
  logic [NL-1:0][W-1:0]  rest_p [N], rest_d [N], rest_q [N];
  logic [SW-1:0]         side_q [N];

  always_comb begin
    rem_p[0]  = '0;
    root_p[0] = '0;
    rest_p[0] = rad_i;
    for (int k = 1; k < N; k++) begin
      rem_p[k]  = rem_q[k-1];
      root_p[k] = root_q[k-1];
      rest_p[k] = rest_q[k-1];
    end
  end

  // bring down two radicand bits, try root*4+1
  always_comb begin
    logic [RW+1:0] rs, tr;
    for (int k = 0; k < N; k++) begin
      for (int l = 0; l < NL; l++) begin
        rs = {rem_p[k][l], rest_p[k][l][W-1 -: 2]};
        tr = (RW + 2)'({root_p[k][l], 2'b01});
        if (rs >= tr) begin
          rem_d[k][l]  = RW'(rs - tr);
          root_d[k][l] = {root_p[k][l][N-2:0], 1'b1};
        end else begin
          rem_d[k][l]  = RW'(rs);
          root_d[k][l] = {root_p[k][l][N-2:0], 1'b0};
        end
        rest_d[k][l] = {rest_p[k][l][W-3:0], 2'b00};
      end
    end
  end

  always_comb begin
    rdy[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < N; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) side_q[0] <= side_i;
    for (int k = 1; k < N; k++) begin
      if (rdy[k]) side_q[k] <= side_q[k-1];
    end
    for (int k = 0; k < N; k++) begin
      if (rdy[k]) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rest_q[k] <= rest_d[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[N-1];
  assign root_o      = root_q[N-1];
  assign side_o      = side_q[N-1];

endmodule

// ----- rtl/c2s_len.sv -----
// scales the cube point by the warp roots and forms the squared length, three stages
// depends on c2s_pkg
module c2s_len (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            in_valid_i,
  output logic                                            in_ready_o,
  input  logic [c2s_pkg::LANES-1:0][c2s_pkg::ROOT_W-1:0]  root_i,
  input  c2s_pkg::warp_side_t                             side_i,
  output logic                                            out_valid_o,
  input  logic                                            out_ready_i,
  output logic [0:0][c2s_pkg::RAD_W-1:0]                  rad_o,
  output c2s_pkg::len_side_t                              side_o
);
  import c2s_pkg::*;

  localparam int STAGES = 3;
  localparam int PW     = MAG_W + ROOT_W + 1;
  localparam int SQW    = 2 * ROOT_W;
  localparam int HALF   = 1 << (FRAC_BITS - 1);

  logic [STAGES-1:0] v_q;
  logic [STAGES:0]   rdy;

  len_side_t                    side_d;
  len_side_t                    side_q [STAGES];
  logic [LANES-1:0][SQW-1:0]    sq_d, sq_q;
  logic [RAD_W-1:0]             rad_d, rad_q;

  always_comb begin
    side_d.bad = side_i.bad;
    side_d.neg = side_i.neg;
    for (int l = 0; l < LANES; l++) begin
      side_d.mag[l] = ROOT_W'((PW'(side_i.mag[l]) * PW'(root_i[l]) + PW'(HALF))
                              >> FRAC_BITS);
      sq_d[l]       = SQW'(side_q[0].mag[l]) * SQW'(side_q[0].mag[l]);
    end
    rad_d = RAD_W'((RAD_W + 2)'(sq_q[0]) + (RAD_W + 2)'(sq_q[1]) + (RAD_W + 2)'(sq_q[2]));
  end

  always_comb begin
    rdy[STAGES] = out_ready_i;
    for (int k = STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) side_q[0] <= side_d;
    for (int k = 1; k < STAGES; k++) begin
      if (rdy[k]) side_q[k] <= side_q[k-1];
    end
    if (rdy[1]) sq_q  <= sq_d;
    if (rdy[2]) rad_q <= rad_d;
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[STAGES-1];
  assign rad_o[0]    = rad_q;
  assign side_o      = side_q[STAGES-1];

endmodule

// ----- rtl/c2s_div.sv -----
// pipelined restoring divider, one quotient bit per stage, several lanes in lockstep
// depends on c2s_pkg; needs num < den << QW
module c2s_div #(
  parameter int NL = c2s_pkg::LANES,
  parameter int NW = c2s_pkg::NUM_W,
  parameter int DW = c2s_pkg::ROOT_W,
  parameter int QW = c2s_pkg::OUT_W,
  parameter int SW = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [NL-1:0][NW-1:0]  num_i,
  input  logic [NL-1:0][DW-1:0]  den_i,
  input  logic [SW-1:0]          side_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [NL-1:0][QW-1:0]  quo_o,
  output logic [SW-1:0]          side_o
);
  import c2s_pkg::*;

  logic [QW-1:0] v_q;
  logic [QW:0]   rdy;

  logic [NL-1:0][DW-1:0] rem_p [QW], rem_d [QW], rem_q [QW];
  logic [NL-1:0][DW-1:0] den_p [QW], den_q [QW];
  logic [NL-1:0][QW-1:0] lo_p [QW], lo_d [QW], lo_q [QW];
  logic [NL-1:0][QW-1:0] quo_p [QW], quo_d [QW], quo_q [QW];
  logic [SW-1:0]         side_q [QW];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      rem_p[0][l] = DW'(num_i[l] >> QW);
      lo_p[0][l]  = num_i[l][QW-1:0];
    end
    den_p[0] = den_i;
    quo_p[0] = '0;
    for (int k = 1; k < QW; k++) begin
      rem_p[k] = rem_q[k-1];
      den_p[k] = den_q[k-1];
      lo_p[k]  = lo_q[k-1];
      quo_p[k] = quo_q[k-1];
    end
  end

  always_comb begin
    logic [DW:0] r2;
    for (int k = 0; k < QW; k++) begin
      for (int l = 0; l < NL; l++) begin
        r2 = {rem_p[k][l], lo_p[k][l][QW-1]};
        if (r2 >= {1'b0, den_p[k][l]}) begin
          rem_d[k][l] = DW'(r2 - {1'b0, den_p[k][l]});
          quo_d[k][l] = {quo_p[k][l][QW-2:0], 1'b1};
        end else begin
          rem_d[k][l] = DW'(r2);
          quo_d[k][l] = {quo_p[k][l][QW-2:0], 1'b0};
        end
        lo_d[k][l] = {lo_p[k][l][QW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    rdy[QW] = out_ready_i;
    for (int k = QW - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < QW; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) side_q[0] <= side_i;
    for (int k = 1; k < QW; k++) begin
      if (rdy[k]) side_q[k] <= side_q[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      if (rdy[k]) begin
        rem_q[k] <= rem_d[k];
        den_q[k] <= den_p[k];
        lo_q[k]  <= lo_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[QW-1];
  assign quo_o       = quo_q[QW-1];
  assign side_o      = side_q[QW-1];

endmodule

// ----- rtl/cube_to_sphere_projection_top.sv -----
// cube to sphere projection, top level: front, two square roots, length, divider, output reg
// depends on c2s_pkg, c2s_front, c2s_sqrt, c2s_len, c2s_div
//
// Takes one point per transaction (cube face and face coordinates u, v in Q1.14,
// clamped to 1.0), warps it onto the sphere with
// p*sqrt(1 - a^2/2 - b^2/2 + a^2*b^2/3) per axis and renormalizes to unit length.
// A new transaction is taken every cycle unless every stage is full and the output
// is held; a point passes the front, warp root, length, length root, divider and
// output register in turn. The two bit-serial square roots and the divider, one
// result bit per stage, make up most of the pipeline depth. Every stage has its own
// valid bit and a stall only holds the stages that are full, so bubbles close up.
// Faces 6 and 7 give the point (0, 0, 0).
module cube_to_sphere_projection_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // face [2:0], u [17:3], v [32:18], zero pad [39:33]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sphere_x [15:0], sphere_y [31:16], sphere_z [47:32]
  output logic [47:0] m_axis_tdata
);
  import c2s_pkg::*;

  localparam int WS_W = $bits(warp_side_t);
  localparam int LS_W = $bits(len_side_t);
  localparam int OS_W = $bits(out_side_t);

  // front to warp root
  logic                          f_valid, f_ready;
  logic [LANES-1:0][RAD_W-1:0]   f_rad;
  warp_side_t                    f_side;

  // warp root to length stage
  logic                          s1_valid, s1_ready;
  logic [LANES-1:0][ROOT_W-1:0]  s1_root;
  logic [WS_W-1:0]               s1_side_w;

  // length stage to length root
  logic                          l_valid, l_ready;
  logic [0:0][RAD_W-1:0]         l_rad;
  len_side_t                     l_side;

  // length root to divider
  logic                          s2_valid, s2_ready;
  logic [0:0][ROOT_W-1:0]        s2_root;
  logic [LS_W-1:0]               s2_side_w;
  len_side_t                     s2_side;

  logic [LANES-1:0][NUM_W-1:0]   d_num;
  logic [LANES-1:0][ROOT_W-1:0]  d_den;
  out_side_t                     d_side_in;

  // divider to output register
  logic                          d_valid, d_ready;
  logic [LANES-1:0][OUT_W-1:0]   d_quo;
  logic [OS_W-1:0]               d_side_w;
  out_side_t                     d_side;

  logic [LANES-1:0][OUT_W-1:0]   res_d, res_q;
  logic                          out_valid_q;

  c2s_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .face_i      (s_axis_tdata[2:0]),
    .u_i         (s_axis_tdata[17:3]),
    .v_i         (s_axis_tdata[32:18]),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .rad_o       (f_rad),
    .side_o      (f_side)
  );

  // warp factor sqrt(T) for each axis
  c2s_sqrt #(.NL(LANES), .W(RAD_W), .SW(WS_W)) u_warp_sqrt (
    .clk_i,
    .rst_ni,
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .rad_i       (f_rad),
    .side_i      (f_side),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .root_o      (s1_root),
    .side_o      (s1_side_w)
  );

  c2s_len u_len (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .root_i      (s1_root),
    .side_i      (warp_side_t'(s1_side_w)),
    .out_valid_o (l_valid),
    .out_ready_i (l_ready),
    .rad_o       (l_rad),
    .side_o      (l_side)
  );

  // vector length, one lane
  c2s_sqrt #(.NL(1), .W(RAD_W), .SW(LS_W)) u_len_sqrt (
    .clk_i,
    .rst_ni,
    .in_valid_i  (l_valid),
    .in_ready_o  (l_ready),
    .rad_i       (l_rad),
    .side_i      (l_side),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .root_o      (s2_root),
    .side_o      (s2_side_w)
  );

  assign s2_side = len_side_t'(s2_side_w);

  // rounded quotient: (|s| << frac + len/2) / len
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      d_num[l] = (NUM_W'(s2_side.mag[l]) << FRAC_BITS) + NUM_W'(s2_root[0] >> 1);
      d_den[l] = s2_root[0];
    end
    d_side_in.zero = s2_side.bad || (s2_root[0] == '0);
    d_side_in.neg  = s2_side.neg;
  end

  c2s_div #(.NL(LANES), .NW(NUM_W), .DW(ROOT_W), .QW(OUT_W), .SW(OS_W)) u_div (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s2_valid),
    .in_ready_o  (s2_ready),
    .num_i       (d_num),
    .den_i       (d_den),
    .side_i      (d_side_in),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .quo_o       (d_quo),
    .side_o      (d_side_w)
  );

  assign d_side = out_side_t'(d_side_w);

  // clamp to one, restore sign, zero for undefined faces or a zero length
  always_comb begin
    logic [OUT_W-1:0] qc;
    for (int l = 0; l < LANES; l++) begin
      qc       = (d_quo[l] > OUT_W'(ONE)) ? OUT_W'(ONE) : d_quo[l];
      res_d[l] = d_side.zero ? '0 : (d_side.neg[l] ? (OUT_W'(0) - qc) : qc);
    end
  end

  // output register parts the result from the pipeline
  assign d_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (d_ready) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ready) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

  // input only backs up when every stage is full and the output is held
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled with room left in the pipeline");

  // a valid face always has one axis at full scale
  a_face_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid && !f_side.bad) |->
      (f_side.mag[0] == MAG_W'(ONE) || f_side.mag[1] == MAG_W'(ONE) ||
       f_side.mag[2] == MAG_W'(ONE)))
    else $error("cube point without a full scale axis");

  // warped point on a valid face never has zero length
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid && !s2_side.bad) |-> (s2_root[0] != '0))
    else $error("zero length for a valid face");

  // each component is at most the length, so the quotient never passes one
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_valid && !d_side.zero) |->
      (d_quo[0] <= OUT_W'(ONE) && d_quo[1] <= OUT_W'(ONE) && d_quo[2] <= OUT_W'(ONE)))
    else $error("normalized component above one");

endmodule
